// ===== rtl/cdq_pkg.sv =====
// Shared definitions for the circular deque: operation codes, the payload word type
// and the command and status bundles exchanged between controller and datapath.
// No dependencies.
package cdq_pkg;

  localparam int unsigned DEPTH_DEF = 16;
  localparam int unsigned WORD_W    = 32;
  localparam int unsigned MODE_W    = 2;

  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic [MODE_W-1:0]        mode_t;

  localparam mode_t MODE_PUSH_FRONT = 2'd0;
  localparam mode_t MODE_PUSH_REAR  = 2'd1;
  localparam mode_t MODE_POP_FRONT  = 2'd2;

  // Controller to datapath.
  typedef struct packed {
    logic accept;  // take the request transaction and update the deque
    logic load;    // move the pending result into the output register
  } cdq_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic is_empty;
    logic is_full;
  } cdq_status_t;

endpackage

// ===== rtl/cdq_if.sv =====
// Valid/ready channel interfaces for the deque request and response transactions.
// Depends on cdq_pkg.
interface cdq_req_if;
  import cdq_pkg::*;
  logic  valid;
  logic  ready;
  mode_t mode;
  word_t push_value;
  modport source (output valid, output mode, output push_value, input ready);
  modport sink   (input valid, input mode, input push_value, output ready);
endinterface

interface cdq_rsp_if;
  import cdq_pkg::*;
  logic  valid;
  logic  ready;
  logic  ok;
  word_t pop_value;
  logic  is_empty;
  logic  is_full;
  modport source (output valid, output ok, output pop_value, output is_empty,
                  output is_full, input ready);
  modport sink   (input valid, input ok, input pop_value, input is_empty,
                  input is_full, output ready);
endinterface

// ===== rtl/cdq_dp.sv =====
// Datapath of the circular deque: slot memory, head and tail pointers, item count
// and the response register. Depends on cdq_pkg.
module cdq_dp #(
  parameter int unsigned DEPTH = cdq_pkg::DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  cdq_pkg::cdq_cmd_t    cmd,
  output cdq_pkg::cdq_status_t status,
  input  cdq_pkg::mode_t       mode,
  input  cdq_pkg::word_t       push_value,
  output logic                 ok,
  output cdq_pkg::word_t       pop_value,
  output logic                 is_empty,
  output logic                 is_full
);
  import cdq_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  word_t            mem [DEPTH];
  word_t            rd_data;
  logic [PTR_W-1:0] head, head_next;
  logic [PTR_W-1:0] tail, tail_next;
  logic [CNT_W-1:0] count, count_next;
  logic [PTR_W-1:0] head_dec, head_inc, tail_inc;
  logic [PTR_W-1:0] wr_addr;
  logic             wr_en;
  logic             do_push_f, do_push_r, do_pop;
  logic             full_now, empty_now;
  logic             pend_ok, pend_pop, pend_empty, pend_full;

  assign full_now  = (count == FULL_CNT);
  assign empty_now = (count == '0);

  assign head_dec = (head == '0)   ? LAST : head - PTR_W'(1);
  assign head_inc = (head == LAST) ? '0   : head + PTR_W'(1);
  assign tail_inc = (tail == LAST) ? '0   : tail + PTR_W'(1);

  assign do_push_f = cmd.accept && (mode == MODE_PUSH_FRONT) && !full_now;
  assign do_push_r = cmd.accept && (mode == MODE_PUSH_REAR)  && !full_now;
  assign do_pop    = cmd.accept && (mode == MODE_POP_FRONT)  && !empty_now;

  assign wr_en   = do_push_f || do_push_r;
  assign wr_addr = do_push_f ? head_dec : tail;

  always_comb begin
    head_next  = head;
    tail_next  = tail;
    count_next = count;
    if (do_push_f) begin
      head_next  = head_dec;
      count_next = count + CNT_W'(1);
    end else if (do_push_r) begin
      tail_next  = tail_inc;
      count_next = count + CNT_W'(1);
    end else if (do_pop) begin
      head_next  = head_inc;
      count_next = count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      head  <= head_next;
      tail  <= tail_next;
      count <= count_next;
    end
  end

  // Slot memory: one write port, one registered read port at the front slot.
  // The front slot is read only as a transaction is accepted, so the word stays
  // put while the result waits, even though the head has already moved on.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= push_value;
    end
    if (cmd.accept) begin
      rd_data <= mem[head];
    end
  end

  // Result of the accepted transaction, held until the output register frees up.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      pend_ok    <= do_push_f || do_push_r || do_pop;
      pend_pop   <= do_pop;
      pend_empty <= (count_next == '0);
      pend_full  <= (count_next == FULL_CNT);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ok        <= pend_ok;
      pop_value <= pend_pop ? rd_data : '0;
      is_empty  <= pend_empty;
      is_full   <= pend_full;
    end
  end

  assign status.is_empty = empty_now;
  assign status.is_full  = full_now;

endmodule

// ===== rtl/cdq_ctrl.sv =====
// Controller of the circular deque: sequences accept and result load, and owns the
// request ready and response valid flags. Depends on cdq_pkg.
module cdq_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_ready,
  output logic                 rsp_valid,
  input  logic                 rsp_ready,
  input  cdq_pkg::cdq_status_t status,
  output cdq_pkg::cdq_cmd_t    cmd
);
  import cdq_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_LOAD = 1'b1;

  logic state, state_next;
  logic rsp_valid_next;

  assign req_ready  = (state == S_IDLE);
  assign cmd.accept = req_valid && req_ready;
  assign cmd.load   = (state == S_LOAD) && (!rsp_valid || rsp_ready);

  always_comb begin
    case (state)
      S_IDLE:  state_next = cmd.accept ? S_LOAD : S_IDLE;
      S_LOAD:  state_next = cmd.load ? S_IDLE : S_LOAD;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.load) begin
      rsp_valid_next = 1'b1;
    end else if (rsp_ready) begin
      rsp_valid_next = 1'b0;
    end else begin
      rsp_valid_next = rsp_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  a_accept_to_load: assert property (@(posedge clk) disable iff (rst)
    cmd.accept |=> (state == S_LOAD))
    else $error("accepted transaction did not move to the load state");

  a_load_gives_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> rsp_valid)
    else $error("loaded result not presented as valid");

  a_no_accept_while_busy: assert property (@(posedge clk) disable iff (rst)
    (state == S_LOAD) |-> !cmd.accept)
    else $error("request accepted while a result is still pending");

  a_status_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(status.is_empty && status.is_full))
    else $error("deque reported empty and full at once");

endmodule

// ===== rtl/circular_deque_top.sv =====
// Top level of the circular deque: joins the controller and the datapath to the
// request and response channels. Depends on cdq_pkg, cdq_if, cdq_ctrl and cdq_dp.
//
//   Channel | Direction | Payload                               | Role
//   req     | in        | mode, push_value                      | push front/rear, pop front
//   rsp     | out       | ok, pop_value, is_empty, is_full      | one result per request
//
// Each request transaction is accepted in the idle state; its result is loaded into
// the response register from the load state once that register is free, after the
// registered read of the slot memory at the front pointer.
// A request is taken while an earlier result still waits in the response register;
// the controller then holds the new result back until that register is drained.
// Reset (rst, synchronous, active high) clears the pointers, the item count and the
// control flags; the slot memory is not cleared and needs no pass after reset.
module circular_deque_top #(
  parameter int unsigned DEPTH = cdq_pkg::DEPTH_DEF
) (
  input logic     clk,
  input logic     rst,
  cdq_req_if.sink   req,
  cdq_rsp_if.source rsp
);
  import cdq_pkg::*;

  cdq_cmd_t    cmd;
  cdq_status_t status;

  // The controller alone decides when a transaction is taken and when its result
  // is published; the datapath acts only on its commands.
  cdq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .status    (status),
    .cmd       (cmd)
  );

  // The datapath holds the slots, the pointers and the response payload register.
  cdq_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .mode       (req.mode),
    .push_value (req.push_value),
    .ok         (rsp.ok),
    .pop_value  (rsp.pop_value),
    .is_empty   (rsp.is_empty),
    .is_full    (rsp.is_full)
  );

endmodule

// ===== sim/deque_scoreboard.sv =====
// Checker for the circular deque: watches the request and response channels,
// keeps its own copy of the deque and compares every response field by field.
// Depends on cdq_pkg and cdq_if.
`timescale 1ns / 1ps

module deque_scoreboard #(
  parameter int unsigned DEPTH = cdq_pkg::DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  cdq_req_if          req,
  cdq_rsp_if          rsp,
  output int unsigned mismatch_count,
  output int unsigned awaiting
);
  import cdq_pkg::*;

  typedef struct packed {
    logic  ok;
    word_t pop_value;
    logic  is_empty;
    logic  is_full;
  } deque_result_t;

  word_t         slot_copy [DEPTH];
  int unsigned   front_idx;
  int unsigned   rear_idx;
  int unsigned   held;
  deque_result_t expected_q [$];
  int unsigned   error_total = 0;

  assign mismatch_count = error_total;

  // Applies one operation to the mirrored deque and returns the response it must cause.
  function automatic deque_result_t apply_op(mode_t op, word_t value);
    deque_result_t r;
    r = '0;
    case (op)
      MODE_PUSH_FRONT: begin
        if (held < DEPTH) begin
          front_idx = (front_idx == 0) ? DEPTH - 1 : front_idx - 1;
          slot_copy[front_idx] = value;
          held++;
          r.ok = 1'b1;
        end
      end
      MODE_PUSH_REAR: begin
        if (held < DEPTH) begin
          slot_copy[rear_idx] = value;
          rear_idx = (rear_idx == DEPTH - 1) ? 0 : rear_idx + 1;
          held++;
          r.ok = 1'b1;
        end
      end
      MODE_POP_FRONT: begin
        if (held != 0) begin
          r.pop_value = slot_copy[front_idx];
          front_idx = (front_idx == DEPTH - 1) ? 0 : front_idx + 1;
          held--;
          r.ok = 1'b1;
        end
      end
      default: begin
      end
    endcase
    r.is_empty = (held == 0);
    r.is_full  = (held == DEPTH);
    return r;
  endfunction

  function automatic void check_field(string field, logic signed [31:0] want,
                                      logic signed [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", field, want, got);
      error_total++;
    end
  endfunction

  always @(posedge clk) begin
    deque_result_t want;
    if (rst) begin
      front_idx = 0;
      rear_idx  = 0;
      held      = 0;
      expected_q.delete();
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (expected_q.size() == 0) begin
          $error("response transaction with none expected: ok=%0b pop_value=%0d",
                 rsp.ok, rsp.pop_value);
          error_total++;
        end else begin
          want = expected_q.pop_front();
          check_field("ok", want.ok, rsp.ok);
          check_field("pop_value", want.pop_value, rsp.pop_value);
          check_field("is_empty", want.is_empty, rsp.is_empty);
          check_field("is_full", want.is_full, rsp.is_full);
        end
      end
      if (req.valid && req.ready)
        expected_q.push_back(apply_op(req.mode, req.push_value));
    end
    awaiting <= expected_q.size();
  end

endmodule

// ===== sim/circular_deque_top_test.sv =====
// Testbench top for the circular deque: drives request transactions, applies
// back-pressure on responses and reports the verdict from deque_scoreboard.
// Depends on cdq_pkg, cdq_if, circular_deque_top and deque_scoreboard.
`timescale 1ns / 1ps

module circular_deque_top_test;
  import cdq_pkg::*;

  // The package names no code for the spare mode value, which must be a no-op.
  localparam mode_t       MODE_UNUSED  = 2'd3;
  localparam int unsigned RANDOM_ITEMS = 700;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned HOLD_CYCLES  = 100;

  logic        clk = 1'b0;
  logic        rst;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned cycle_count = 0;

  // Pacing controls. Both are written with nonblocking assignments so that the
  // response side reads them the same way whatever the process order.
  logic        calm;
  int unsigned hold_ask;

  cdq_req_if req_ch ();
  cdq_rsp_if rsp_ch ();

  circular_deque_top u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  deque_scoreboard u_scoreboard (
    .clk            (clk),
    .rst            (rst),
    .req            (req_ch),
    .rsp            (rsp_ch),
    .mismatch_count (fail_count),
    .awaiting       (pending)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Response side. Normally ready drops in roughly a quarter of the cycles; in the
  // calm phase it stays high. On request it holds off for a long stretch, which
  // lets the response register fill and a result wait behind it, so that req.ready falls.
  initial begin
    int unsigned hold_left;
    int unsigned hold_seen;
    hold_left = 0;
    hold_seen = 0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_ask != hold_seen) begin
        hold_seen = hold_ask;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= calm || ($urandom_range(99) >= 24);
      end
    end
  end

  // Offers one request transaction and returns at the edge where it is taken.
  // Any idle gap comes first, so valid is never dropped and raised in one step.
  task automatic offer(mode_t op, word_t value);
    while (!calm && $urandom_range(99) < 24) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.mode       <= op;
    req_ch.push_value <= value;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  // Waits until every transaction sent so far has had its response. The first
  // edge lets the checker record the transaction taken at the current one.
  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Mostly random words, with the extremes turning up often.
  function automatic word_t rand_word();
    case ($urandom_range(9))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'hFFFF_FFFF;
      3:       return 32'h0000_0000;
      default: return $urandom;
    endcase
  endfunction

  // Picks an operation; push_pct steers the fill level so that both the full and
  // the empty ends are visited again and again.
  function automatic mode_t pick_mode(int unsigned push_pct);
    if ($urandom_range(99) < 3)
      return MODE_UNUSED;
    if ($urandom_range(99) < push_pct)
      return $urandom_range(1) ? MODE_PUSH_REAR : MODE_PUSH_FRONT;
    return MODE_POP_FRONT;
  endfunction

  initial begin
    int unsigned burst;
    int unsigned push_pct;
    int unsigned n;
    rst               <= 1'b1;
    req_ch.valid      <= 1'b0;
    req_ch.mode       <= MODE_PUSH_FRONT;
    req_ch.push_value <= '0;
    calm              <= 1'b0;
    hold_ask          <= 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part: refusals on an empty deque, the spare mode, the word
    // extremes, a front push wrapping the index below zero, then a full fill with
    // refused pushes and a spare mode while full.
    offer(MODE_POP_FRONT, 32'h1234_5678);
    offer(MODE_UNUSED, 32'hDEAD_BEEF);
    offer(MODE_PUSH_FRONT, 32'h7FFF_FFFF);
    offer(MODE_PUSH_REAR, 32'h8000_0000);
    offer(MODE_POP_FRONT, 32'h0);
    offer(MODE_POP_FRONT, 32'hFFFF_FFFF);
    offer(MODE_POP_FRONT, 32'h0);
    for (int i = 0; i < DEPTH_DEF; i++)
      offer((i % 2) ? MODE_PUSH_REAR : MODE_PUSH_FRONT,
            (i % 3 == 0) ? 32'hAAAA_5555 ^ i : 32'h5555_AAAA ^ i);
    offer(MODE_PUSH_FRONT, 32'hFFFF_FFFF);
    offer(MODE_PUSH_REAR, 32'h0);
    offer(MODE_UNUSED, 32'h0);

    // Random part, in bursts that lean towards filling, draining or neither.
    // Along the way: one long response hold-off while requests keep coming, one
    // pause until the deque has answered everything, and a calm stretch with no
    // idling on either side.
    n = 0;
    while (n < RANDOM_ITEMS) begin
      burst = $urandom_range(40, 8);
      case ($urandom_range(2))
        0:       push_pct = 80;
        1:       push_pct = 20;
        default: push_pct = 50;
      endcase
      for (int k = 0; k < burst && n < RANDOM_ITEMS; k++) begin
        if (n == 200)
          hold_ask <= hold_ask + 1;
        if (n == 350)
          wait_drained();
        if (n == 450)
          calm <= 1'b1;
        if (n == 550)
          calm <= 1'b0;
        offer(pick_mode(push_pct), rand_word());
        n++;
      end
    end

    wait_drained();
    repeat (10) @(posedge clk);
    if (fail_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/cdq_pkg.sv
rtl/cdq_if.sv
rtl/cdq_dp.sv
rtl/cdq_ctrl.sv
rtl/circular_deque_top.sv
sim/deque_scoreboard.sv
sim/circular_deque_top_test.sv
